// File: rtl/aiq_pkg.sv
`default_nettype none

package aiq_pkg;

  localparam int SAMPLE_WIDTH   = 16;
  localparam int PROD_WIDTH     = SAMPLE_WIDTH + 9;
  localparam int DIVIDEND_WIDTH = SAMPLE_WIDTH + 9;
  localparam int DIVISOR_WIDTH  = SAMPLE_WIDTH + 1;
  localparam int REM_WIDTH      = SAMPLE_WIDTH + 2;
  localparam int COUNT_WIDTH    = $clog2(DIVIDEND_WIDTH + 1);
  localparam int SUM_WIDTH      = DIVIDEND_WIDTH + 2;

  localparam logic signed [7:0] CODE_MIN = -8'sd128;
  localparam logic signed [7:0] CODE_MAX = 8'sd127;

  typedef enum logic {
    OP_OBSERVE  = 1'b0,
    OP_QUANTIZE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_ZP_DIV,
    ST_Q_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e                             operation;
    logic signed [SAMPLE_WIDTH-1:0]  sample;
    logic                            last;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0]               quantized;
    logic signed [7:0]               zp_code;
    logic signed [SAMPLE_WIDTH-1:0]  range_low;
    logic signed [SAMPLE_WIDTH-1:0]  range_high;
    logic                            last_out;
  } out_item_t;

  typedef struct packed {
    logic load_item;
    logic observe;
    logic div_start;
    logic div_sel_zp;
    logic div_step;
    logic zp_write;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic quantize;
    logic zp_ready;
    logic div_done;
    logic out_free;
  } status_t;

  function automatic logic signed [7:0] clamp_code(input logic signed [SUM_WIDTH-1:0] v);
    logic signed [7:0] r;
    if (v < SUM_WIDTH'(CODE_MIN)) begin
      r = CODE_MIN;
    end else if (v > SUM_WIDTH'(CODE_MAX)) begin
      r = CODE_MAX;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/affine_int8_quantizer_core.sv
// Affine int8 quantizer. Each transfer on the input channel carries one item:
// an observe item widens the running minimum and maximum, a quantize item maps
// its sample to an int8 code with the zero point derived from that range.
// Every item gives exactly one transfer on the output channel, in order.
// One item is in work at a time. A quantize item's rounding divide runs one
// quotient bit per cycle over 25 bits on a shared restoring divider; the first
// quantize item after reset, after an observe item or after the last item of a
// quantize pass first runs the zero point divide.
// The output register holds a finished result while the receiver stalls, and
// the next item is accepted meanwhile; it completes its work and then waits
// until that register is free.
// Reset clears the range and the cached zero point; the next observe item
// starts a new range.
`default_nettype none

module affine_int8_quantizer_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  aiq_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output aiq_pkg::out_item_t  out_data_o
);

  aiq_pkg::cmd_t    cmd;
  aiq_pkg::status_t status;

  aiq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  aiq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// File: rtl/aiq_ctrl.sv
`default_nettype none

module aiq_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  aiq_pkg::status_t    status_i,
  output aiq_pkg::cmd_t       cmd_o
);

  aiq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aiq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      aiq_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = aiq_pkg::ST_DECIDE;
        end
      end
      aiq_pkg::ST_DECIDE: begin
        if (!status_i.quantize) begin
          cmd_o.observe = 1'b1;
          state_d       = aiq_pkg::ST_DONE;
        end else if (!status_i.zp_ready) begin
          cmd_o.div_start  = 1'b1;
          cmd_o.div_sel_zp = 1'b1;
          state_d          = aiq_pkg::ST_ZP_DIV;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = aiq_pkg::ST_Q_DIV;
        end
      end
      aiq_pkg::ST_ZP_DIV: begin
        if (status_i.div_done) begin
          cmd_o.zp_write  = 1'b1;
          cmd_o.div_start = 1'b1;
          state_d         = aiq_pkg::ST_Q_DIV;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      aiq_pkg::ST_Q_DIV: begin
        if (status_i.div_done) begin
          state_d = aiq_pkg::ST_DONE;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      aiq_pkg::ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = aiq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = aiq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/aiq_dp.sv
`default_nettype none

module aiq_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  aiq_pkg::in_item_t        in_data_i,
  input  aiq_pkg::cmd_t            cmd_i,
  output aiq_pkg::status_t         status_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output aiq_pkg::out_item_t       out_data_o
);

  localparam int W  = aiq_pkg::SAMPLE_WIDTH;
  localparam int PW = aiq_pkg::PROD_WIDTH;
  localparam int NW = aiq_pkg::DIVIDEND_WIDTH;
  localparam int DW = aiq_pkg::DIVISOR_WIDTH;
  localparam int RW = aiq_pkg::REM_WIDTH;
  localparam int CW = aiq_pkg::COUNT_WIDTH;
  localparam int SW = aiq_pkg::SUM_WIDTH;

  aiq_pkg::in_item_t    item_q;

  logic signed [W-1:0]  min_q, min_d;
  logic signed [W-1:0]  max_q, max_d;
  logic                 range_valid_q, range_valid_d;
  logic                 restart_q, restart_d;
  logic signed [7:0]    zp_q, zp_d;
  logic                 zp_ready_q, zp_ready_d;

  logic [RW-1:0]        rem_q, rem_d;
  logic [NW-1:0]        quo_q, quo_d;
  logic [DW-1:0]        div_q, div_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 neg_q, neg_d;
  logic                 sel_zp_q, sel_zp_d;

  logic                 out_valid_q, out_valid_d;
  aiq_pkg::out_item_t   out_q;

  logic signed [W:0]    diff;
  logic                 usable;
  logic signed [PW-1:0] base;
  logic signed [PW-1:0] prod;
  logic [PW-1:0]        mag;
  logic [RW-1:0]        shifted;
  logic                 fits;
  logic signed [NW:0]   rounded;
  logic signed [SW-1:0] sum;
  logic signed [7:0]    clamped;

  assign diff   = (W+1)'(max_q) - (W+1)'(min_q);
  assign usable = range_valid_q && (diff > '0);

  // The product by 255 is a shift and a subtract.
  assign base = cmd_i.div_sel_zp ? -PW'(min_q) : PW'(item_q.sample);
  assign prod = (base <<< 8) - base;
  assign mag  = prod[PW-1] ? PW'(-prod) : PW'(prod);

  assign shifted = {rem_q[RW-2:0], quo_q[NW-1]};
  assign fits    = shifted >= RW'(div_q);

  assign rounded = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign sum     = SW'(rounded) + (sel_zp_q ? SW'(aiq_pkg::CODE_MIN) : SW'(zp_q));
  assign clamped = aiq_pkg::clamp_code(sum);

  always_comb begin
    min_d         = min_q;
    max_d         = max_q;
    range_valid_d = range_valid_q;
    restart_d     = restart_q;
    zp_d          = zp_q;
    zp_ready_d    = zp_ready_q;
    rem_d         = rem_q;
    quo_d         = quo_q;
    div_d         = div_q;
    cnt_d         = cnt_q;
    neg_d         = neg_q;
    sel_zp_d      = sel_zp_q;
    out_valid_d   = out_valid_q && out_stall_i;

    if (cmd_i.observe) begin
      if (restart_q) begin
        min_d         = item_q.sample;
        max_d         = item_q.sample;
        range_valid_d = 1'b1;
        restart_d     = 1'b0;
      end else begin
        if (item_q.sample < min_q) begin
          min_d = item_q.sample;
        end
        if (item_q.sample > max_q) begin
          max_d = item_q.sample;
        end
      end
      zp_ready_d = 1'b0;
      if (item_q.last) begin
        restart_d = 1'b1;
      end
    end

    if (cmd_i.zp_write) begin
      zp_d       = usable ? clamped : 8'sd0;
      zp_ready_d = 1'b1;
    end

    if (cmd_i.div_start) begin
      // Rounding half away from zero: (2|n| + r) / (2r).
      rem_d    = '0;
      quo_d    = {mag[NW-2:0], 1'b0} + NW'(diff[W-1:0]);
      div_d    = {diff[W-1:0], 1'b0};
      cnt_d    = CW'(NW);
      neg_d    = prod[PW-1];
      sel_zp_d = cmd_i.div_sel_zp;
    end else if (cmd_i.div_step) begin
      rem_d = fits ? shifted - RW'(div_q) : shifted;
      quo_d = {quo_q[NW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
    end

    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
      if (item_q.operation == aiq_pkg::OP_QUANTIZE) begin
        restart_d = 1'b1;
        if (item_q.last) begin
          zp_ready_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q         <= '0;
      max_q         <= '0;
      range_valid_q <= 1'b0;
      restart_q     <= 1'b1;
      zp_q          <= '0;
      zp_ready_q    <= 1'b0;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      min_q         <= min_d;
      max_q         <= max_d;
      range_valid_q <= range_valid_d;
      restart_q     <= restart_d;
      zp_q          <= zp_d;
      zp_ready_q    <= zp_ready_d;
      cnt_q         <= cnt_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
    end
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    div_q    <= div_d;
    neg_q    <= neg_d;
    sel_zp_q <= sel_zp_d;
    if (cmd_i.out_load) begin
      out_q.range_low  <= min_q;
      out_q.range_high <= max_q;
      out_q.last_out   <= item_q.last;
      if (item_q.operation == aiq_pkg::OP_QUANTIZE) begin
        out_q.quantized <= usable ? clamped : 8'sd0;
        out_q.zp_code   <= zp_q;
      end else begin
        out_q.quantized <= 8'sd0;
        out_q.zp_code   <= 8'sd0;
      end
    end
  end

  assign status_o.quantize = (item_q.operation == aiq_pkg::OP_QUANTIZE);
  assign status_o.zp_ready = zp_ready_q;
  assign status_o.div_done = (cnt_q == '0);
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
